// ===== src/cbba_pkg.sv =====
// Package with the action codes, status codes and sequencer states of the block allocator.
`timescale 1ns / 1ps

package cbba_pkg;

  localparam int ACTION_W = 2;
  localparam int LEN_W    = 9;
  localparam int BLK_W    = 8;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_FIND  = 2'd0,
    ACT_FLIP  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK           = 2'd0,
    STATUS_NOT_FOUND    = 2'd1,
    STATUS_OUT_OF_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FIND,
    ST_FLIP,
    ST_QUERY,
    ST_CLEAR,
    ST_RESP
  } state_t;

endpackage

// ===== src/contiguous_block_bitmap_allocator.sv =====
// First-fit contiguous bitmap allocator: one map memory walked by a single address sequencer.
// One item is in work at a time: no new item is taken until its result is loaded into the output register.
// After reset a clearing pass writes every map entry free before items are taken.
`timescale 1ns / 1ps

module contiguous_block_bitmap_allocator #(
  parameter int BLOCKS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [cbba_pkg::ACTION_W-1:0]   in_action,
  input  logic [cbba_pkg::LEN_W-1:0]      in_run_length,
  input  logic [cbba_pkg::BLK_W-1:0]      in_start_block,
  input  logic [cbba_pkg::BLK_W-1:0]      in_query_block,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cbba_pkg::STATUS_W-1:0]   out_status,
  output logic [cbba_pkg::BLK_W-1:0]      out_run_start,
  output logic                            out_block_used
);
  import cbba_pkg::*;

  localparam int IW = $clog2(BLOCKS);
  localparam int EW = (IW + 1 > LEN_W + 1) ? IW + 1 : LEN_W + 1;
  localparam int SW = (IW > BLK_W) ? IW : BLK_W;

  logic mem [BLOCKS];
  logic rd_data_r;
  logic [IW-1:0] rd_addr;
  logic mem_we;
  logic [IW-1:0] mem_waddr;
  logic mem_wdata;

  state_t state_r, state_nxt;
  logic [IW-1:0] clr_r, clr_nxt;
  logic [IW:0] iss_r, iss_nxt;
  logic p_vld_r, p_vld_nxt;
  logic [IW-1:0] p_idx_r, p_idx_nxt;
  logic [LEN_W-1:0] run_r, run_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [IW-1:0] start_r, start_nxt;
  logic [EW-1:0] cur_r, cur_nxt;
  logic [EW-1:0] end_r, end_nxt;
  status_t res_status_r, res_status_nxt;
  logic [BLK_W-1:0] res_start_r, res_start_nxt;
  logic res_used_r, res_used_nxt;
  logic out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [BLK_W-1:0] out_start_r;
  logic out_used_r;

  logic in_take;
  logic can_load;
  logic bit_free;
  logic find_hit;
  logic find_last;
  logic flip_issue;
  logic flip_done;
  logic clr_last;
  logic q_oob;
  logic [EW-1:0] q_ext;
  logic [EW-1:0] flip_sum;
  logic [IW-1:0] hit_start;
  logic [SW-1:0] hit_start_ext;

  assign in_take       = in_valid && (state_r == ST_IDLE);
  assign can_load      = !out_valid_r || !out_stall;
  assign bit_free      = !rd_data_r;
  assign find_hit      = p_vld_r && bit_free && (LEN_W'(run_r + 1'b1) == len_r);
  assign find_last     = p_vld_r && (p_idx_r == IW'(BLOCKS - 1));
  assign flip_issue    = cur_r < end_r;
  assign flip_done     = !flip_issue && !p_vld_r;
  assign clr_last      = clr_r == IW'(BLOCKS - 1);
  assign q_ext         = EW'(in_query_block);
  assign q_oob         = q_ext >= EW'(BLOCKS);
  assign flip_sum      = EW'(in_start_block) + EW'(in_run_length);
  assign hit_start     = (run_r == '0) ? p_idx_r : start_r;
  assign hit_start_ext = SW'(hit_start);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_take) begin
          unique case (action_t'(in_action))
            ACT_FIND:  state_nxt = (in_run_length == '0) ? ST_RESP : ST_FIND;
            ACT_FLIP:  state_nxt = ST_FLIP;
            ACT_QUERY: state_nxt = q_oob ? ST_RESP : ST_QUERY;
            ACT_CLEAR: state_nxt = ST_CLEAR;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FIND: begin
        if (find_hit || find_last) state_nxt = ST_RESP;
      end
      ST_FLIP: begin
        if (flip_done) state_nxt = ST_RESP;
      end
      ST_QUERY: state_nxt = ST_RESP;
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (can_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_nxt        = clr_r;
    iss_nxt        = iss_r;
    p_vld_nxt      = 1'b0;
    p_idx_nxt      = p_idx_r;
    run_nxt        = run_r;
    len_nxt        = len_r;
    start_nxt      = start_r;
    cur_nxt        = cur_r;
    end_nxt        = end_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    res_used_nxt   = res_used_r;
    rd_addr        = iss_r[IW-1:0];
    mem_we         = 1'b0;
    mem_waddr      = clr_r;
    mem_wdata      = 1'b0;
    unique case (state_r)
      ST_INIT, ST_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = IW'(clr_r + 1'b1);
      end
      ST_IDLE: begin
        rd_addr        = q_ext[IW-1:0];
        iss_nxt        = '0;
        run_nxt        = '0;
        clr_nxt        = '0;
        len_nxt        = in_run_length;
        cur_nxt        = EW'(in_start_block);
        end_nxt        = (flip_sum > EW'(BLOCKS)) ? EW'(BLOCKS) : flip_sum;
        res_status_nxt = STATUS_OK;
        res_start_nxt  = '0;
        res_used_nxt   = 1'b0;
        if (in_take) begin
          unique case (action_t'(in_action))
            ACT_FIND: begin
              if (in_run_length == '0) res_status_nxt = STATUS_NOT_FOUND;
            end
            ACT_FLIP: begin
              if (flip_sum > EW'(BLOCKS)) res_status_nxt = STATUS_OUT_OF_RANGE;
            end
            ACT_QUERY: begin
              if (q_oob) res_status_nxt = STATUS_OUT_OF_RANGE;
            end
            ACT_CLEAR: res_status_nxt = STATUS_OK;
            default:   res_status_nxt = STATUS_OK;
          endcase
        end
      end
      ST_FIND: begin
        rd_addr   = iss_r[IW-1:0];
        p_vld_nxt = iss_r < (IW + 1)'(BLOCKS);
        p_idx_nxt = iss_r[IW-1:0];
        iss_nxt   = (IW + 1)'(iss_r + 1'b1);
        if (p_vld_r) begin
          if (bit_free) begin
            run_nxt = LEN_W'(run_r + 1'b1);
            if (run_r == '0) start_nxt = p_idx_r;
          end else begin
            run_nxt = '0;
          end
          if (find_hit) begin
            res_status_nxt = STATUS_OK;
            res_start_nxt  = hit_start_ext[BLK_W-1:0];
          end else if (find_last) begin
            res_status_nxt = STATUS_NOT_FOUND;
          end
        end
      end
      ST_FLIP: begin
        rd_addr   = cur_r[IW-1:0];
        p_vld_nxt = flip_issue;
        p_idx_nxt = cur_r[IW-1:0];
        if (flip_issue) cur_nxt = EW'(cur_r + 1'b1);
        mem_we    = p_vld_r;
        mem_waddr = p_idx_r;
        mem_wdata = !rd_data_r;
      end
      ST_QUERY: res_used_nxt = rd_data_r;
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_r       <= '0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      p_vld_r <= p_vld_nxt;
      if (state_r == ST_RESP && can_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    iss_r        <= iss_nxt;
    p_idx_r      <= p_idx_nxt;
    run_r        <= run_nxt;
    len_r        <= len_nxt;
    start_r      <= start_nxt;
    cur_r        <= cur_nxt;
    end_r        <= end_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    res_used_r   <= res_used_nxt;
    if (state_r == ST_RESP && can_load) begin
      out_status_r <= res_status_r;
      out_start_r  <= res_start_r;
      out_used_r   <= res_used_r;
    end
  end

  assign in_stall       = state_r != ST_IDLE;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_run_start  = out_start_r;
  assign out_block_used = out_used_r;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != ST_IDLE))
    else $error("Accepted item did not start work.");

  a_not_found_zero_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_NOT_FOUND) |-> (out_run_start == '0))
    else $error("Failed find reports a nonzero run start.");

  a_used_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_block_used) |-> (out_status == STATUS_OK))
    else $error("Used mark reported with a failing status.");

  a_resp_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && can_load) |=> (out_valid && state_r == ST_IDLE))
    else $error("Result was not loaded into the output register.");
`endif

endmodule

// ===== tb/sv/tb_contiguous_block_bitmap_allocator.sv =====
// Self-checking testbench for the first-fit contiguous block bitmap allocator.
`timescale 1ns / 1ps

module tb_contiguous_block_bitmap_allocator;
  import cbba_pkg::*;

  localparam int BLOCKS       = 256;
  localparam int RANDOM_ITEMS = 1500;
  localparam int QUIET_LIMIT  = 4000;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    action_t          action;
    logic [LEN_W-1:0] run_length;
    logic [BLK_W-1:0] start_block;
    logic [BLK_W-1:0] query_block;
    bit               drain_first;
  } request_t;

  typedef struct {
    status_t          status;
    logic [BLK_W-1:0] run_start;
    logic             block_used;
  } reply_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [ACTION_W-1:0] in_action;
  logic [LEN_W-1:0]    in_run_length;
  logic [BLK_W-1:0]    in_start_block;
  logic [BLK_W-1:0]    in_query_block;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [BLK_W-1:0]    out_run_start;
  logic                out_block_used;

  request_t          pending_items[$];
  reply_t            expected_replies[$];
  request_t          cur_req;
  logic [BLOCKS-1:0] plan_map;
  logic [BLOCKS-1:0] model_map;
  int                extent_start[$];
  int                extent_len[$];
  int                items_planned;
  int                accepted_items;
  int                results_seen;
  int                mismatches;
  int                quiet_cycles;
  int                action_count[4];
  int                found_count;
  int                past_end_count;
  bit                in_fire;
  logic              calm;

  assign calm = accepted_items >= 600 && accepted_items < 800;

  contiguous_block_bitmap_allocator #(.BLOCKS(BLOCKS)) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_run_length (in_run_length),
    .in_start_block(in_start_block),
    .in_query_block(in_query_block),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_run_start (out_run_start),
    .out_block_used(out_block_used)
  );

  function automatic reply_t serve_request(inout logic [BLOCKS-1:0] map, input request_t req);
    reply_t rep;
    int     run;
    int     len;
    int     idx;
    bit     found;
    rep.status     = STATUS_OK;
    rep.run_start  = '0;
    rep.block_used = 1'b0;
    len = int'(req.run_length);
    case (req.action)
      ACT_FIND: begin
        rep.status = STATUS_NOT_FOUND;
        run = 0;
        found = 1'b0;
        for (int i = 0; i < BLOCKS; i++) begin
          run = map[i] ? 0 : run + 1;
          if (!found && len != 0 && run == len) begin
            found = 1'b1;
            rep.status = STATUS_OK;
            rep.run_start = BLK_W'(i + 1 - len);
          end
        end
      end
      ACT_FLIP: begin
        for (int k = 0; k < len; k++) begin
          idx = int'(req.start_block) + k;
          if (idx < BLOCKS) map[idx] = ~map[idx];
        end
        if (int'(req.start_block) + len > BLOCKS) rep.status = STATUS_OUT_OF_RANGE;
      end
      ACT_QUERY: rep.block_used = map[req.query_block];
      default: map = '0;
    endcase
    return rep;
  endfunction

  function automatic reply_t add_item(action_t act, int len, int first, int qblk, bit drain);
    request_t req;
    req.action      = act;
    req.run_length  = LEN_W'(len);
    req.start_block = BLK_W'(first);
    req.query_block = BLK_W'(qblk);
    req.drain_first = drain;
    if (act != ACT_FLIP) req.start_block = BLK_W'($urandom_range(0, 255));
    if (act != ACT_QUERY) req.query_block = BLK_W'($urandom_range(0, 255));
    if (act == ACT_QUERY || act == ACT_CLEAR) req.run_length = LEN_W'($urandom_range(0, 511));
    pending_items.push_back(req);
    items_planned++;
    return serve_request(plan_map, req);
  endfunction

  function automatic int pick_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 8);
    if (roll < 93) return $urandom_range(9, 48);
    return $urandom_range(49, BLOCKS);
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ACT_FIND;
    in_run_length  = '0;
    in_start_block = '0;
    in_query_block = '0;
    out_stall      = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 16);
      if (!in_valid || in_fire) begin
        if (pending_items.size() == 0 ||
            (pending_items[0].drain_first && expected_replies.size() != 0) ||
            (!calm && $urandom_range(0, 99) < 16)) begin
          in_valid <= 1'b0;
        end else begin
          cur_req = pending_items.pop_front();
          in_valid       <= 1'b1;
          in_action      <= cur_req.action;
          in_run_length  <= cur_req.run_length;
          in_start_block <= cur_req.start_block;
          in_query_block <= cur_req.query_block;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    reply_t want;
    bit     out_fire;
    in_fire  = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    if (in_fire) begin
      want = serve_request(model_map, cur_req);
      expected_replies.push_back(want);
      accepted_items++;
      action_count[cur_req.action]++;
      if (cur_req.action == ACT_FIND && want.status == STATUS_OK) found_count++;
      if (want.status == STATUS_OUT_OF_RANGE) past_end_count++;
    end
    if (out_fire) begin
      results_seen++;
      if (expected_replies.size() == 0) begin
        note_mismatch($sformatf("unexpected result status=%0d run_start=%0d block_used=%0d",
                                out_status, out_run_start, out_block_used));
      end else begin
        want = expected_replies.pop_front();
        if (out_status !== want.status || out_run_start !== want.run_start ||
            out_block_used !== want.block_used)
          note_mismatch($sformatf(
              "result %0d: expected status=%0d run_start=%0d block_used=%0d, got %0d/%0d/%0d",
              results_seen, want.status, want.run_start, want.block_used,
              out_status, out_run_start, out_block_used));
      end
    end
    quiet_cycles = (in_fire || out_fire) ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: nothing moved for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, expected_replies.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    reply_t rep;
    int     roll;
    int     len;
    int     pick;
    bit     drain;
    plan_map  = '0;
    model_map = '0;

    void'(add_item(ACT_QUERY, 0, 0, 0, 1'b0));
    void'(add_item(ACT_QUERY, 0, 0, 255, 1'b0));
    void'(add_item(ACT_FIND, 0, 0, 0, 1'b0));
    void'(add_item(ACT_FIND, 1, 0, 0, 1'b0));
    void'(add_item(ACT_FIND, 256, 0, 0, 1'b0));
    void'(add_item(ACT_FIND, 257, 0, 0, 1'b0));
    void'(add_item(ACT_FIND, 511, 0, 0, 1'b0));
    void'(add_item(ACT_FLIP, 0, 0, 0, 1'b0));
    void'(add_item(ACT_FLIP, 1, 0, 0, 1'b0));
    void'(add_item(ACT_QUERY, 0, 0, 0, 1'b0));
    void'(add_item(ACT_FIND, 1, 0, 0, 1'b0));
    void'(add_item(ACT_FLIP, 10, 250, 0, 1'b0));
    void'(add_item(ACT_QUERY, 0, 0, 255, 1'b0));
    void'(add_item(ACT_FIND, 249, 0, 0, 1'b0));
    void'(add_item(ACT_FIND, 250, 0, 0, 1'b0));
    void'(add_item(ACT_FLIP, 1, 255, 0, 1'b0));
    void'(add_item(ACT_FLIP, 256, 0, 0, 1'b0));
    void'(add_item(ACT_FLIP, 511, 128, 0, 1'b0));
    void'(add_item(ACT_FLIP, 511, 255, 0, 1'b0));
    void'(add_item(ACT_QUERY, 0, 0, 128, 1'b0));
    void'(add_item(ACT_CLEAR, 0, 0, 0, 1'b1));
    void'(add_item(ACT_QUERY, 0, 0, 0, 1'b0));
    void'(add_item(ACT_FIND, 256, 0, 0, 1'b0));

    // Most traffic allocates first-fit extents and frees them again.
    while (items_planned < 23 + RANDOM_ITEMS) begin
      roll  = $urandom_range(0, 99);
      drain = ($urandom_range(0, 199) == 0);
      if (roll < 40) begin
        len = pick_length();
        rep = add_item(ACT_FIND, len, 0, 0, drain);
        if (rep.status == STATUS_OK) begin
          void'(add_item(ACT_FLIP, len, int'(rep.run_start), 0, 1'b0));
          extent_start.push_back(int'(rep.run_start));
          extent_len.push_back(len);
        end
      end else if (roll < 65 && extent_start.size() > 0) begin
        pick = $urandom_range(0, extent_start.size() - 1);
        void'(add_item(ACT_FLIP, extent_len[pick], extent_start[pick], 0, drain));
        extent_start.delete(pick);
        extent_len.delete(pick);
      end else if (roll < 82) begin
        void'(add_item(ACT_QUERY, 0, 0, $urandom_range(0, 255), drain));
      end else if (roll < 90) begin
        len = $urandom_range(0, 1) ? pick_length() : $urandom_range(0, 511);
        void'(add_item(ACT_FLIP, len, $urandom_range(0, 255), 0, drain));
      end else if (roll < 98) begin
        len = $urandom_range(0, 1) ? pick_length() : $urandom_range(0, 511);
        void'(add_item(ACT_FIND, len, 0, 0, drain));
      end else begin
        void'(add_item(ACT_CLEAR, 0, 0, 0, drain));
        extent_start.delete();
        extent_len.delete();
      end
    end

    while (accepted_items < items_planned) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items: %0d finds (%0d found), %0d flips, %0d queries, %0d clears.",
             accepted_items, action_count[ACT_FIND], found_count, action_count[ACT_FLIP],
             action_count[ACT_QUERY], action_count[ACT_CLEAR]);
    $display("Checked %0d results, %0d ranges ran past the end, %0d mismatches counted.",
             results_seen, past_end_count, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
